// File: hdl/kdq_pkg.sv
package kdq_pkg;

  localparam int CAPACITY_DEF = 16;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_DELETE     = 3'd4,
    ACT_SEARCH     = 3'd5,
    ACT_SWAP       = 3'd6,
    ACT_NONE       = 3'd7
  } action_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_RD_DATA,
    ST_SCAN_ISSUE,
    ST_SCAN_CHECK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_SWAP_RD,
    ST_SWAP_WR,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic mem_rd;     // read memory at rd position
    logic mem_wr;     // write memory
    logic wr_sel;     // 0: write key, 1: write rd data
    logic [1:0] wpos; // 0 front-1, 1 count, 2 scan pos, 3 q pos
    logic [1:0] rpos; // 0 front, 1 count-1, 2 scan pos, 3 scan pos+1
    logic scan_clr;
    logic scan_inc;
    logic found1_set;
    logic found2_set;
    logic cnt_inc;
    logic cnt_dec;
    logic front_dec;
    logic front_inc;
    logic set_val;
    logic set_ok;
    logic set_ferr;
    logic hold_tmp;   // swap: write second key at p
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_t action;
    logic empty;
    logic full;
    logic scan_end;   // scan pos == count
    logic shift_end;  // scan pos+1 >= count
    logic match1;
    logic match2;
    logic found1;
    logic found2;
    logic ge2;
    logic out_busy;
  } stat_t;

endpackage

// File: hdl/kdq_if.sv
interface kdq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic signed [31:0] key;
  logic signed [31:0] second_key;
  modport source (output valid, action, key, second_key, input ready);
  modport sink (input valid, action, key, second_key, output ready);
endinterface

interface kdq_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic signed [31:0] value;
  logic [4:0]  count;
  logic        full_error;
  modport source (output valid, ok, value, count, full_error, input ready);
  modport sink (input valid, ok, value, count, full_error, output ready);
endinterface

// File: hdl/kdq_ctrl.sv
module kdq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  kdq_pkg::stat_t st,
  output kdq_pkg::cmd_t  cmd
);
  import kdq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_RD_WAIT;
        end
      end
      ST_RD_WAIT: begin
        unique case (st.action)
          ACT_PUSH_FRONT: begin
            if (st.full) cmd.set_ferr = 1'b1;
            else begin
              cmd.mem_wr = 1'b1; cmd.wpos = 2'd0;
              cmd.front_dec = 1'b1; cmd.cnt_inc = 1'b1; cmd.set_ok = 1'b1;
            end
            state_nxt = ST_DONE;
          end
          ACT_PUSH_BACK: begin
            if (st.full) cmd.set_ferr = 1'b1;
            else begin
              cmd.mem_wr = 1'b1; cmd.wpos = 2'd1;
              cmd.cnt_inc = 1'b1; cmd.set_ok = 1'b1;
            end
            state_nxt = ST_DONE;
          end
          ACT_POP_FRONT, ACT_POP_BACK: begin
            if (st.empty) state_nxt = ST_DONE;
            else begin
              cmd.mem_rd = 1'b1;
              cmd.rpos = (st.action == ACT_POP_FRONT) ? 2'd0 : 2'd1;
              state_nxt = ST_RD_DATA;
            end
          end
          ACT_DELETE, ACT_SEARCH, ACT_SWAP: begin
            cmd.scan_clr = 1'b1;
            if (st.action == ACT_SWAP && !st.ge2) state_nxt = ST_DONE;
            else state_nxt = ST_SCAN_ISSUE;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_RD_DATA: begin
        cmd.set_val = 1'b1; cmd.set_ok = 1'b1; cmd.cnt_dec = 1'b1;
        cmd.front_inc = (st.action == ACT_POP_FRONT);
        state_nxt = ST_DONE;
      end
      ST_SCAN_ISSUE: begin
        if (st.scan_end) begin
          // no match (or only one swap key found)
          state_nxt = ST_DONE;
        end else begin
          cmd.mem_rd = 1'b1; cmd.rpos = 2'd2;
          state_nxt = ST_SCAN_CHECK;
        end
      end
      ST_SCAN_CHECK: begin
        state_nxt = ST_SCAN_ISSUE;
        cmd.scan_inc = 1'b1;
        if (st.action == ACT_SWAP) begin
          if (st.match1 && !st.found1) cmd.found1_set = 1'b1;
          if (st.match2 && !st.found2) cmd.found2_set = 1'b1;
          if ((st.found1 || st.match1) && (st.found2 || st.match2)) begin
            cmd.scan_inc = 1'b0;
            state_nxt = ST_SWAP_RD;
          end
        end else if (st.match1) begin
          cmd.scan_inc = 1'b0;
          if (st.action == ACT_SEARCH) begin
            cmd.set_ok = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SHIFT_RD;
          end
        end
      end
      ST_SHIFT_RD: begin
        if (st.shift_end) begin
          cmd.cnt_dec = 1'b1; cmd.set_ok = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cmd.mem_rd = 1'b1; cmd.rpos = 2'd3;
          state_nxt = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        cmd.mem_wr = 1'b1; cmd.wr_sel = 1'b1; cmd.wpos = 2'd2;
        cmd.scan_inc = 1'b1;
        state_nxt = ST_SHIFT_RD;
      end
      ST_SWAP_RD: begin
        // first key goes to q; p gets the second key next cycle
        cmd.mem_wr = 1'b1; cmd.wpos = 2'd3;
        state_nxt = ST_SWAP_WR;
      end
      ST_SWAP_WR: begin
        cmd.hold_tmp = 1'b1;
        cmd.set_ok = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && state_r == ST_IDLE) begin
      assert (cmd.mem_wr == 1'b0) else $error("write while idle");
    end
  end

  property p_scan_from_issue;
    @(posedge clk) disable iff (!rst_n)
      state_r == ST_SCAN_CHECK |-> $past(state_r) == ST_SCAN_ISSUE;
  endproperty
  a_scan_from_issue: assert property (p_scan_from_issue) else $error("bad scan order");

  property p_ready_idle;
    @(posedge clk) disable iff (!rst_n) in_ready |-> state_r == ST_IDLE;
  endproperty
  a_ready_idle: assert property (p_ready_idle) else $error("ready outside idle");

  property p_done_exit;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_DONE && !st.out_busy) |=> state_r == ST_IDLE;
  endproperty
  a_done_exit: assert property (p_done_exit) else $error("stuck in done");

endmodule

// File: hdl/kdq_dp.sv
module kdq_dp #(
  parameter int CAPACITY = kdq_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  kdq_in_if.sink        in_ch,
  kdq_out_if.source     out_ch,
  input  kdq_pkg::cmd_t  cmd,
  output kdq_pkg::stat_t st
);
  import kdq_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW:0] CAP_W = (CW+1)'(CAPACITY);

  logic [31:0] mem [CAPACITY];

  action_t     act_r;
  logic [31:0] k1_r, k2_r;
  logic [AW-1:0] front_r;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] scan_r;   // scan pos (p)
  logic [CW-1:0] qpos_r;   // swap q pos
  logic          f1_r, f2_r;
  logic [31:0]   rd_r;
  logic          ok_r, ferr_r, val_set_r;
  logic          ovalid_r, ook_r, oferr_r;
  logic [31:0]   oval_r;
  logic [4:0]    ocnt_r;

  // logical position -> physical slot, mod CAPACITY via compare/subtract
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] f, input logic [CW:0] pos);
    logic [CW+1:0] s;
    s = (CW+2)'(f) + (CW+2)'(pos);
    if (s >= (CW+2)'(CAPACITY)) s = s - (CW+2)'(CAPACITY);
    return s[AW-1:0];
  endfunction

  logic [AW-1:0] front_m1, front_p1;
  assign front_m1 = (front_r == '0) ? AW'(CAPACITY - 1) : front_r - 1'b1;
  assign front_p1 = (front_r == AW'(CAPACITY - 1)) ? '0 : front_r + 1'b1;

  // swap scan position: whichever of scan_r / qpos_r is still moving
  logic [CW-1:0] sw_pos;
  assign sw_pos = (f1_r) ? qpos_r : scan_r;

  logic [AW-1:0] raddr, waddr;
  logic [31:0]   wdata;
  always_comb begin
    case (cmd.rpos)
      2'd0: raddr = front_r;
      2'd1: raddr = slot(front_r, (CW+1)'(cnt_r) - 1'b1);
      2'd2: raddr = slot(front_r, (CW+1)'((act_r == ACT_SWAP) ? sw_pos : scan_r));
      default: raddr = (act_r == ACT_SWAP) ? slot(front_r, (CW+1)'(qpos_r))
                                           : slot(front_r, (CW+1)'(scan_r) + 1'b1);
    endcase
    case (cmd.wpos)
      2'd0: waddr = front_m1;
      2'd1: waddr = slot(front_r, (CW+1)'(cnt_r));
      2'd2: waddr = slot(front_r, (CW+1)'(scan_r));
      default: waddr = slot(front_r, (CW+1)'(qpos_r));
    endcase
    wdata = cmd.wr_sel ? rd_r : k1_r;
  end

  // swap: entry p holds k1 and entry q holds k2, so the exchange is k1 -> q
  // (regular write) followed by k2 -> p here
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[waddr] <= wdata;
    else if (cmd.hold_tmp) mem[slot(front_r, (CW+1)'(scan_r))] <= k2_r;
    if (cmd.mem_rd) rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action_t'(in_ch.action);
      k1_r <= in_ch.key;
      k2_r <= in_ch.second_key;
    end
  end

  logic match1, match2;
  assign match1 = (rd_r == k1_r);
  assign match2 = (rd_r == k2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0; cnt_r <= '0; scan_r <= '0; qpos_r <= '0;
      f1_r <= 1'b0; f2_r <= 1'b0; ok_r <= 1'b0; ferr_r <= 1'b0; val_set_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        ok_r <= 1'b0; ferr_r <= 1'b0; val_set_r <= 1'b0;
      end
      if (cmd.front_dec) front_r <= front_m1;
      if (cmd.front_inc) front_r <= front_p1;
      if (cmd.cnt_inc) cnt_r <= cnt_r + 1'b1;
      if (cmd.cnt_dec) cnt_r <= cnt_r - 1'b1;
      if (cmd.scan_clr) begin
        scan_r <= '0; qpos_r <= '0; f1_r <= 1'b0; f2_r <= 1'b0;
      end
      // swap: scan_r keeps p once found1, qpos_r tracks q
      if (cmd.scan_inc) begin
        if (act_r == ACT_SWAP) begin
          if (!(f1_r || cmd.found1_set)) scan_r <= scan_r + 1'b1;
          if (!(f2_r || cmd.found2_set)) qpos_r <= qpos_r + 1'b1;
        end else scan_r <= scan_r + 1'b1;
      end
      if (cmd.found1_set) f1_r <= 1'b1;
      if (cmd.found2_set) f2_r <= 1'b1;
      if (cmd.set_ok) ok_r <= 1'b1;
      if (cmd.set_ferr) ferr_r <= 1'b1;
      if (cmd.set_val) val_set_r <= 1'b1;
      if (cmd.out_load) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ook_r <= ok_r;
      oferr_r <= ferr_r;
      oval_r <= val_set_r ? rd_r : '0;
      ocnt_r <= 5'(cnt_r);
    end
  end

  always_comb begin
    st.action = act_r;
    st.empty = (cnt_r == '0);
    st.full = ((CW+1)'(cnt_r) >= CAP_W);
    st.scan_end = ((act_r == ACT_SWAP) ? sw_pos : scan_r) == cnt_r;
    st.shift_end = ((CW+1)'(scan_r) + 1'b1) >= (CW+1)'(cnt_r);
    st.match1 = match1;
    st.match2 = match2;
    st.found1 = f1_r;
    st.found2 = f2_r;
    st.ge2 = ((CW+1)'(cnt_r) >= (CW+1)'(2));
    st.out_busy = ovalid_r && !out_ch.ready;
  end

  assign in_ch.ready = 1'b0 | cmd.load | 1'b0;
  assign out_ch.valid = ovalid_r;
  assign out_ch.ok = ook_r;
  assign out_ch.value = oval_r;
  assign out_ch.count = ocnt_r;
  assign out_ch.full_error = oferr_r;

  property p_cnt_bound;
    @(posedge clk) disable iff (!rst_n) (CW+1)'(cnt_r) <= CAP_W;
  endproperty
  a_cnt_bound: assert property (p_cnt_bound) else $error("count overflow");

  property p_out_hold;
    @(posedge clk) disable iff (!rst_n)
      (ovalid_r && !out_ch.ready) |=> ovalid_r && $stable(oval_r);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped");

  property p_cnt_step;
    @(posedge clk) disable iff (!rst_n)
      !(cmd.cnt_inc || cmd.cnt_dec) |=> $stable(cnt_r);
  endproperty
  a_cnt_step: assert property (p_cnt_step) else $error("count moved");

endmodule

// File: hdl/keyed_deque_with_search.sv
// Channel | Dir | Handshake     | Payload
// in_     | in  | valid/ready   | action[2:0], key[31:0], second_key[31:0]
// out_    | out | valid/ready   | ok, value[31:0], count[4:0], full_error
//
// One request at a time. A push writes its entry directly and a pop reads
// its entry first; the result is then loaded into the output register.
// Search, delete and swap walk the entry memory, reading each entry and then
// checking it; delete then shifts later entries by a read and a write each
// and swap then writes the first key at q and the second key at p.
// rst_n is synchronous; it clears front, count and control, not the entries.
// A stalled result is held in the output register; the next request is
// still taken, and its result waits until the held one has been handed off.
module keyed_deque_with_search #(
  parameter int CAPACITY = kdq_pkg::CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  kdq_in_if.sink    in_ch,
  kdq_out_if.source out_ch
);
  import kdq_pkg::*;

  cmd_t  cmd;
  stat_t st;
  logic  ctrl_ready;

  kdq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(ctrl_ready),
    .st(st), .cmd(cmd)
  );

  kdq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cmd(cmd), .st(st)
  );

  // controller's ready must agree with the datapath's acceptance
  property p_ready_match;
    @(posedge clk) disable iff (!rst_n) (ctrl_ready && in_ch.valid) |-> in_ch.ready;
  endproperty
  a_ready_match: assert property (p_ready_match) else $error("ready mismatch");

endmodule
